>>> design/tbc_pkg.sv
// ---------------------------------------------------------------------------
// tbc_pkg
// Shared widths, register indexes and types of the threshold boundary
// classifier.
// ---------------------------------------------------------------------------
package tbc_pkg;

  // fixed field widths
  localparam int DIM_W   = 11;   // image_width / image_height registers
  localparam int THR_W   = 8;    // threshold register
  localparam int PIX_W   = 8;    // pixel intensity
  localparam int COORD_W = 10;   // reported col / row
  localparam int CFG_IDX_W = 2;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_THRESHOLD    = 2'd0,
    CFG_IMAGE_WIDTH  = 2'd1,
    CFG_IMAGE_HEIGHT = 2'd2
  } cfg_idx_t;

  // input word kinds
  localparam logic KIND_PIXEL = 1'b0;
  localparam logic KIND_FLUSH = 1'b1;

  // reset geometry
  localparam logic [DIM_W-1:0] DIM_RESET = 11'd1024;

  // one line-store entry: above-threshold bit of row slot 0 and slot 1
  typedef logic [1:0] line_word_t;

endpackage

>>> design/tbc_line_store.sv
// ---------------------------------------------------------------------------
// tbc_line_store
// Two-row store of above-threshold bits, one 2-bit word per column. Two
// synchronous read ports (registered), one write port, and bypass of
// a write landing on the same edge as a read of the same column.
// ---------------------------------------------------------------------------
module tbc_line_store
  import tbc_pkg::*;
#(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr_a,
  input  logic [AW-1:0]    rd_addr_b,
  output line_word_t       rd_data_a,
  output line_word_t       rd_data_b,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  line_word_t       wr_data
);

  line_word_t mem [DEPTH];

  line_word_t rd_a_r;
  line_word_t rd_b_r;
  line_word_t byp_word_r;
  logic       byp_a_r;
  logic       byp_b_r;

  // memory array: write port and two registered read ports
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_a_r <= mem[rd_addr_a];
      rd_b_r <= mem[rd_addr_b];
    end
  end

  // bypass: read and write of one column on the same edge
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byp_a_r <= 1'b0;
      byp_b_r <= 1'b0;
    end else if (rd_en) begin
      byp_a_r <= wr_en && (wr_addr == rd_addr_a);
      byp_b_r <= wr_en && (wr_addr == rd_addr_b);
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      byp_word_r <= wr_data;
    end
  end

  assign rd_data_a = byp_a_r ? byp_word_r : rd_a_r;
  assign rd_data_b = byp_b_r ? byp_word_r : rd_b_r;

endmodule

>>> design/threshold_boundary_classifier.sv
// ---------------------------------------------------------------------------
// threshold_boundary_classifier
// Binary threshold of a raster pixel stream with 4-neighbor boundary marks.
// ---------------------------------------------------------------------------
// Takes one word per clock, back to back, unless stage 1 stalls, and gives
// at most one result word per input word. The result for pixel (r-1, c)
// comes out with the input word at (r, c), through stage 1 and the output
// register; words of row 0 give no result, and after a frame one row of
// image_width words (flush ticks or any kind) drains the last row. The line
// store holds a 2-bit word per column, two rows of above-threshold bits,
// read at columns c and c+1 in the accept cycle and written back as stage 1
// moves on, with a bypass for a write and read of the same column. It needs
// no clearing pass; its contents only matter after one full row has passed.
// Geometry registers are clamped to 1..MAX_WIDTH and 1..MAX_HEIGHT and should
// be written only while the block is idle.
// ---------------------------------------------------------------------------
module threshold_boundary_classifier
  import tbc_pkg::*;
#(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic                 clk,
  input  logic                 rst_n,
  // configuration
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DIM_W-1:0]     cfg_wdata,
  // input words
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 in_kind,
  input  logic [PIX_W-1:0]     in_pixel_value,
  // result words
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [COORD_W-1:0]   out_col,
  output logic [COORD_W-1:0]   out_row,
  output logic                 out_is_white,
  output logic                 out_is_edge,
  output logic                 out_frame_last
);

  localparam int CW    = $clog2(MAX_WIDTH);
  localparam int RW    = $clog2(MAX_HEIGHT + 1);
  localparam int MAXCR = (CW > RW) ? CW : RW;
  localparam int CMPW  = ((MAXCR > DIM_W) ? MAXCR : DIM_W) + 2;

  localparam logic [CMPW-1:0] MAX_W_C = CMPW'(MAX_WIDTH);
  localparam logic [CMPW-1:0] MAX_H_C = CMPW'(MAX_HEIGHT);
  localparam logic [CMPW-1:0] ONE_C   = CMPW'(1);
  localparam logic [CMPW-1:0] TWO_C   = CMPW'(2);

  // configuration registers
  logic [THR_W-1:0] threshold_r;
  logic [DIM_W-1:0] image_width_r;
  logic [DIM_W-1:0] image_height_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      threshold_r    <= '0;
      image_width_r  <= DIM_RESET;
      image_height_r <= DIM_RESET;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_THRESHOLD:    threshold_r    <= cfg_wdata[THR_W-1:0];
        CFG_IMAGE_WIDTH:  image_width_r  <= cfg_wdata;
        CFG_IMAGE_HEIGHT: image_height_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // clamped geometry
  logic [CMPW-1:0] w_raw, h_raw, w_c, h_c;

  assign w_raw = CMPW'(image_width_r);
  assign h_raw = CMPW'(image_height_r);

  always_comb begin
    if (w_raw == '0)          w_c = ONE_C;
    else if (w_raw > MAX_W_C) w_c = MAX_W_C;
    else                      w_c = w_raw;
    if (h_raw == '0)          h_c = ONE_C;
    else if (h_raw > MAX_H_C) h_c = MAX_H_C;
    else                      h_c = h_raw;
  end

  // scan position
  logic [CW-1:0] scan_col_r, scan_col_nxt;
  logic [RW-1:0] scan_row_r, scan_row_nxt;

  logic [CMPW-1:0] c0, r0, c1, r1, c1_inc;
  logic            cur;
  logic            in_acc;

  // effective position after a geometry shrink, then the step forward
  always_comb begin
    c0 = CMPW'(scan_col_r);
    r0 = CMPW'(scan_row_r);
    c1 = c0;
    r1 = r0;
    if (c0 >= w_c) begin
      c1 = '0;
      r1 = r0 + ONE_C;
    end
    if (r1 > h_c) begin
      r1 = '0;
    end
    c1_inc = c1 + ONE_C;

    if (c1_inc >= w_c) begin
      scan_col_nxt = '0;
      scan_row_nxt = (r1 >= h_c) ? '0 : RW'(r1 + ONE_C);
    end else begin
      scan_col_nxt = CW'(c1_inc);
      scan_row_nxt = RW'(r1);
    end
  end

  assign cur    = (r1 < h_c) && (in_kind == KIND_PIXEL) && (in_pixel_value > threshold_r);
  assign in_acc = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_col_r <= '0;
      scan_row_r <= '0;
    end else if (in_acc) begin
      scan_col_r <= scan_col_nxt;
      scan_row_r <= scan_row_nxt;
    end
  end

  // stage 1: line store data arrives
  logic          s1_v_r;
  logic [CW-1:0] s1_col_r;
  logic [RW-1:0] s1_row_r;
  logic          s1_cur_r;
  logic          s1_has_res_r;
  logic          s1_left_ok_r;
  logic          s1_right_ok_r;
  logic          s1_up_ok_r;
  logic          s1_last_r;
  logic          left_bit_r;

  logic out_valid_r;
  logic out_free;
  logic s1_go;

  assign out_free = !out_valid_r || out_ready;
  assign s1_go    = s1_v_r && (!s1_has_res_r || out_free);
  assign in_ready = !s1_v_r || s1_go;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_acc) begin
      s1_v_r <= 1'b1;
    end else if (s1_go) begin
      s1_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_col_r      <= CW'(c1);
      s1_row_r      <= RW'(r1);
      s1_cur_r      <= cur;
      s1_has_res_r  <= (r1 != '0);
      s1_left_ok_r  <= (c1 != '0);
      s1_right_ok_r <= (c1_inc < w_c);
      s1_up_ok_r    <= (r1 >= TWO_C);
      s1_last_r     <= (r1 == h_c) && (c1_inc == w_c);
    end
  end

  // line store
  line_word_t word_c, word_n, wr_word;
  logic       slot;
  logic       center, left_b, right_b, up_b, all_b;

  tbc_line_store #(
    .DEPTH (MAX_WIDTH),
    .AW    (CW)
  ) u_line_store (
    .clk       (clk),
    .rst_n     (rst_n),
    .rd_en     (in_acc),
    .rd_addr_a (CW'(c1)),
    .rd_addr_b (CW'(c1_inc)),
    .rd_data_a (word_c),
    .rd_data_b (word_n),
    .wr_en     (s1_go),
    .wr_addr   (s1_col_r),
    .wr_data   (wr_word)
  );

  // neighborhood: slot of this row holds row r-2, the other slot row r-1
  assign slot    = s1_row_r[0];
  assign center  = word_c[~slot];
  assign up_b    = s1_up_ok_r && word_c[slot];
  assign right_b = s1_right_ok_r && word_n[~slot];
  assign left_b  = s1_left_ok_r && left_bit_r;
  assign all_b   = left_b && right_b && up_b && s1_cur_r;

  // write back: this row's bit replaces row r-2, row r-1 kept
  always_comb begin
    wr_word        = '0;
    wr_word[slot]  = s1_cur_r;
    wr_word[~slot] = center;
  end

  // previous row bit of this column is the left neighbor of the next one
  always_ff @(posedge clk) begin
    if (s1_go) begin
      left_bit_r <= center;
    end
  end

  // output register
  logic [RW-1:0]         prev_row;
  logic [RW+COORD_W-1:0] row_ext;
  logic [CW+COORD_W-1:0] col_ext;

  assign prev_row = s1_row_r - RW'(1);
  assign row_ext  = {{COORD_W{1'b0}}, prev_row};
  assign col_ext  = {{COORD_W{1'b0}}, s1_col_r};

  logic [COORD_W-1:0] out_col_r, out_row_r;
  logic               out_is_white_r, out_is_edge_r, out_frame_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_go && s1_has_res_r) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && s1_has_res_r) begin
      out_col_r        <= col_ext[COORD_W-1:0];
      out_row_r        <= row_ext[COORD_W-1:0];
      out_is_white_r   <= center;
      out_is_edge_r    <= center && !all_b;
      out_frame_last_r <= s1_last_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_col        = out_col_r;
  assign out_row        = out_row_r;
  assign out_is_white   = out_is_white_r;
  assign out_is_edge    = out_is_edge_r;
  assign out_frame_last = out_frame_last_r;

  // checks
  a_acc_fills_s1: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> s1_v_r)
    else $error("accepted word did not reach stage 1");

  a_stall_blocks_in: assert property (@(posedge clk) disable iff (!rst_n)
    s1_v_r && s1_has_res_r && out_valid_r && !out_ready |-> !in_ready)
    else $error("input taken while stage 1 is stalled");

  a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    s1_go && s1_has_res_r |=> out_valid_r)
    else $error("stage 1 result was dropped");

  a_edge_is_white: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (!out_is_edge_r || out_is_white_r))
    else $error("edge word on a pixel that is not white");

endmodule
